### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the zone filter.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising edge once reset is released
`define SZPF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check prop at every rising edge, reset included
`define SZPF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/szpf_pkg.sv
// ---------------------------------------------------------------------------
// szpf_pkg
// Types shared by the zone filter and its cells, and the filter's operation codes.
// ---------------------------------------------------------------------------
package szpf_pkg;

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_CLEAR    = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;

  typedef struct packed {
    logic found;
    logic hit;
  } link_t;

  typedef struct packed {
    logic en;
    logic append;
  } wr_cmd_t;

endpackage

### rtl/sphere_zone_point_filter.sv
// ---------------------------------------------------------------------------
// sphere_zone_point_filter
// Zone table with a point-in-any-sphere test, one zone per cell.
//
//   channel | valid       | stall       | payload
//   in      | in_valid_i  | in_stall_o  | op_i, zone_*_i, point_*_i, has_position_i
//   out     | out_valid_o | out_stall_i | in_any_zone_o, keep_record_o, zone_count_o,
//           |             |             | table_full_o
//
// An item runs from accept to the next accept through the distance pipeline
// in every cell, then the match and hit flags ripple one cell per cycle down
// the chain.
// One item is in flight at a time; the output register holds a result
// while the next item is taken.
// Reset clears the zone count and all handshake state; no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sphere_zone_point_filter #(
  parameter int MAX_ZONES   = 8,
  parameter int COORD_WIDTH = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       op_i,
  input  logic [15:0]                      zone_tag_i,
  input  logic [COORD_WIDTH-1:0]           zone_x_i,
  input  logic [COORD_WIDTH-1:0]           zone_y_i,
  input  logic [COORD_WIDTH-1:0]           zone_z_i,
  input  logic [COORD_WIDTH-2:0]           zone_radius_i,
  input  logic [COORD_WIDTH-1:0]           point_x_i,
  input  logic [COORD_WIDTH-1:0]           point_y_i,
  input  logic [COORD_WIDTH-1:0]           point_z_i,
  input  logic                             has_position_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             in_any_zone_o,
  output logic                             keep_record_o,
  output logic [$clog2(MAX_ZONES+1)-1:0]   zone_count_o,
  output logic                             table_full_o
);

  localparam int CW    = COORD_WIDTH;
  localparam int CNT_W = $clog2(MAX_ZONES + 1);
  localparam int LAT   = MAX_ZONES + 4;
  localparam int TMR_W = $clog2(LAT + 1);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e             state_q;
  logic [TMR_W-1:0]   tmr_q;
  logic [CNT_W-1:0]   count_q;

  logic [1:0]         op_q;
  logic [15:0]        tag_q;
  logic [CW-1:0]      zx_q, zy_q, zz_q;
  logic [CW-2:0]      zr_q;
  logic [CW-1:0]      px_q, py_q, pz_q;
  logic               has_pos_q;

  logic               out_valid_q;
  logic               in_zone_q;
  logic               keep_q;
  logic [CNT_W-1:0]   out_count_q;
  logic               full_q;

  szpf_pkg::link_t    link [MAX_ZONES+1];
  szpf_pkg::wr_cmd_t  wr;

  logic               in_accept;
  logic               out_free;
  logic               finish;
  logic               room;
  logic               found;
  logic               hit;
  logic [CNT_W-1:0]   count_d;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign finish    = (state_q == S_RUN) && (tmr_q == TMR_W'(LAT)) && out_free;
  assign room      = count_q < CNT_W'(MAX_ZONES);
  assign found     = link[MAX_ZONES].found;
  assign hit       = link[MAX_ZONES].hit;

  assign link[0] = '0;

  always_comb begin
    wr.en     = finish && (op_q == szpf_pkg::OP_REGISTER) && (found || room);
    wr.append = !found;
    count_d   = count_q;
    case (op_q)
      szpf_pkg::OP_REGISTER: begin
        if (!found && room) begin
          count_d = count_q + 1'b1;
        end
      end
      szpf_pkg::OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  for (genvar k = 0; k < MAX_ZONES; k++) begin : g_cell
    szpf_cell #(
      .CW    (CW),
      .CNT_W (CNT_W),
      .IDX   (k)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .tag_i         (tag_q),
      .zone_x_i      (zx_q),
      .zone_y_i      (zy_q),
      .zone_z_i      (zz_q),
      .zone_radius_i (zr_q),
      .point_x_i     (px_q),
      .point_y_i     (py_q),
      .point_z_i     (pz_q),
      .count_i       (count_q),
      .wr_i          (wr),
      .link_i        (link[k]),
      .link_o        (link[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q      <= op_i;
      tag_q     <= zone_tag_i;
      zx_q      <= zone_x_i;
      zy_q      <= zone_y_i;
      zz_q      <= zone_z_i;
      zr_q      <= zone_radius_i;
      px_q      <= point_x_i;
      py_q      <= point_y_i;
      pz_q      <= point_z_i;
      has_pos_q <= has_position_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tmr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      in_zone_q   <= 1'b0;
      keep_q      <= 1'b0;
      out_count_q <= '0;
      full_q      <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= S_RUN;
            tmr_q   <= '0;
          end
        end
        S_RUN: begin
          if (tmr_q != TMR_W'(LAT)) begin
            tmr_q <= tmr_q + 1'b1;
          end else if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      if (finish) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
        in_zone_q   <= (op_q == szpf_pkg::OP_QUERY) && hit;
        keep_q      <= (op_q == szpf_pkg::OP_QUERY) &&
                       ((count_q == '0) || !has_pos_q || hit);
        out_count_q <= count_d;
        full_q      <= (op_q == szpf_pkg::OP_REGISTER) && !found && !room;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o    = state_q != S_IDLE;
  assign out_valid_o   = out_valid_q;
  assign in_any_zone_o = in_zone_q;
  assign keep_record_o = keep_q;
  assign zone_count_o  = out_count_q;
  assign table_full_o  = full_q;

  `SZPF_ASSERT(a_count_in_range, clk_i, rst_ni, count_q <= CNT_W'(MAX_ZONES), "zone count exceeds table size")
  `SZPF_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_accept |=> in_stall_o, "not busy after accept")
  `SZPF_ASSERT(a_full_only_when_full, clk_i, rst_ni, (out_valid_o && table_full_o) |-> (zone_count_o == CNT_W'(MAX_ZONES)), "drop reported with free slots")
  `SZPF_ASSERT(a_hit_keeps, clk_i, rst_ni, (out_valid_o && in_any_zone_o) |-> (keep_record_o && (zone_count_o != '0)), "hit without keep or zones")

endmodule

### rtl/szpf_cell.sv
// ---------------------------------------------------------------------------
// szpf_cell
// One zone slot: holds a zone, tests the broadcast point against it and
// passes match and hit flags on to the next cell.
// ---------------------------------------------------------------------------
module szpf_cell #(
  parameter int CW    = 24,
  parameter int CNT_W = 4,
  parameter int IDX   = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [15:0]          tag_i,
  input  logic [CW-1:0]        zone_x_i,
  input  logic [CW-1:0]        zone_y_i,
  input  logic [CW-1:0]        zone_z_i,
  input  logic [CW-2:0]        zone_radius_i,
  input  logic [CW-1:0]        point_x_i,
  input  logic [CW-1:0]        point_y_i,
  input  logic [CW-1:0]        point_z_i,
  input  logic [CNT_W-1:0]     count_i,
  input  szpf_pkg::wr_cmd_t    wr_i,
  input  szpf_pkg::link_t      link_i,
  output szpf_pkg::link_t      link_o
);

  logic [15:0]     tag_q;
  logic [CW-1:0]   x_q, y_q, z_q;
  logic [CW-2:0]   r_q;

  logic [CW-1:0]   dx_q, dy_q, dz_q;
  logic [CW-2:0]   r1_q;
  logic            m1_q, m2_q, m3_q, m4_q;
  logic [2*CW-1:0] sqx_q, sqy_q, sqz_q, sqz3_q;
  logic [2*CW-3:0] r2_q, r23_q;
  logic [2*CW:0]   s12_q;
  logic            inside_q;

  logic            valid;
  logic            tail;
  logic            sel_q;
  szpf_pkg::link_t link_q, link_d;

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] d;
    logic [CW:0] m;
    d = {a[CW-1], a} - {b[CW-1], b};
    m = d[CW] ? (~d + 1'b1) : d;
    return m[CW-1:0];
  endfunction

  assign valid = CNT_W'(IDX) < count_i;
  assign tail  = CNT_W'(IDX) == count_i;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.append ? tail : sel_q)) begin
      tag_q <= tag_i;
      x_q   <= zone_x_i;
      y_q   <= zone_y_i;
      z_q   <= zone_z_i;
      r_q   <= zone_radius_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q   <= abs_diff(point_x_i, x_q);
    dy_q   <= abs_diff(point_y_i, y_q);
    dz_q   <= abs_diff(point_z_i, z_q);
    r1_q   <= r_q;
    m1_q   <= tag_q == tag_i;
    sqx_q  <= {{CW{1'b0}}, dx_q} * {{CW{1'b0}}, dx_q};
    sqy_q  <= {{CW{1'b0}}, dy_q} * {{CW{1'b0}}, dy_q};
    sqz_q  <= {{CW{1'b0}}, dz_q} * {{CW{1'b0}}, dz_q};
    r2_q   <= {{(CW-1){1'b0}}, r1_q} * {{(CW-1){1'b0}}, r1_q};
    m2_q   <= m1_q;
    s12_q  <= {1'b0, sqx_q} + {1'b0, sqy_q};
    sqz3_q <= sqz_q;
    r23_q  <= r2_q;
    m3_q   <= m2_q;
    inside_q <= ({1'b0, s12_q} + {2'b00, sqz3_q}) <= {4'b0000, r23_q};
    m4_q   <= m3_q;
  end

  always_comb begin
    link_d.found = link_i.found | (valid & m4_q);
    link_d.hit   = link_i.hit | (valid & inside_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
      sel_q  <= 1'b0;
    end else begin
      link_q <= link_d;
      sel_q  <= valid & m4_q & ~link_i.found;
    end
  end

  assign link_o = link_q;

endmodule
